### sv/mibp_pkg.sv
// ----------------------------------------------------------------------------
// MIDI input byte parser package
// Shared types and codes for the byte parser and its port checker.
// ----------------------------------------------------------------------------
`default_nettype none

package mibp_pkg;

  // Input commands.
  typedef enum logic [1:0] {
    CMD_DATA  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_RESET = 2'd3
  } cmd_e;

  // Result kinds.
  typedef enum logic [2:0] {
    KIND_SHORT  = 3'd0,
    KIND_SXBYTE = 3'd1,
    KIND_DONE   = 3'd2,
    KIND_ERROR  = 3'd3,
    KIND_STRAY  = 3'd4
  } kind_e;

  // Byte values with a meaning of their own.
  localparam logic [7:0] BYTE_SX_START = 8'hF0;
  localparam logic [7:0] BYTE_SX_END   = 8'hF7;
  localparam logic [7:0] BYTE_RT_FIRST = 8'hF8;

  // Chunk length after reset, and the saturation limit of the fill count.
  localparam logic [15:0] CHUNK_LEN_RESET = 16'd256;
  localparam logic [15:0] FILL_MAX        = 16'hFFFF;

  // Result queue: two slots per item plus two for the item behind it.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One result item.
  typedef struct packed {
    kind_e       kind;
    logic [23:0] packed_msg;
    logic [7:0]  sx_data;
    logic [15:0] chunk;
    logic [31:0] stamp;
    logic        last;
  } result_t;

  // Partial short message.
  typedef struct packed {
    logic [7:0] status;
    logic [6:0] first;
    logic [6:0] second;
    logic [1:0] count;
  } pend_t;

  // Outcome of handling one byte outside SysEx.
  typedef struct packed {
    pend_t       pend;
    logic        sysex;
    logic [15:0] fill;
    logic        hit;
    result_t     res;
  } outside_t;

endpackage

`default_nettype wire

### sv/midi_input_byte_parser.sv
// ----------------------------------------------------------------------------
// MIDI input byte parser
// Packs MIDI 1.0 bytes into short messages, SysEx bytes and chunk results.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                        Handshake
//  input     command_i, data_byte_i, time_stamp_i           in_valid_i / in_stall_o
//  result    kind_o, packed_message_o, sysex_data_o,        out_valid_o / out_stall_i
//            chunk_bytes_o, result_time_o, last_o
//  config    cfg_data_i (sysex_chunk_length)                cfg_valid_i / cfg_ready_o
//
//  An accepted item is held in the input register and parsed from there,
//  pushing its zero, one or two results into a four-entry result queue once
//  two entries are free; each result then shows on the port from the queue.
//  The result port drains one result per cycle while out_stall_i is low.
//  The input stalls only while the queue has fewer than two free entries.
//  Reset clears the parser state and the queue and sets the chunk length to 256.
//
`default_nettype none

module midi_input_byte_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input items
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mibp_pkg::cmd_e      command_i,
  input  logic [7:0]          data_byte_i,
  input  logic [31:0]         time_stamp_i,
  // Result items
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mibp_pkg::kind_e     kind_o,
  output logic [23:0]         packed_message_o,
  output logic [7:0]          sysex_data_o,
  output logic [15:0]         chunk_bytes_o,
  output logic [31:0]         result_time_o,
  output logic                last_o,
  // Configuration
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [15:0]         cfg_data_i
);

  import mibp_pkg::*;

  // Message length in bytes for a status byte.
  function automatic logic [1:0] msg_len(input logic [7:0] s);
    logic [1:0] len;
    case (s[7:4])
      4'hC, 4'hD: len = 2'd2;
      4'hF: begin
        if (s == 8'hF1 || s == 8'hF3) begin
          len = 2'd2;
        end else if (s == 8'hF2) begin
          len = 2'd3;
        end else begin
          len = 2'd1;
        end
      end
      default: len = 2'd3;
    endcase
    return len;
  endfunction

  // Builds one result with its last flag cleared.
  function automatic result_t mk_res(input kind_e k, input logic [23:0] p,
                                     input logic [7:0] sx, input logic [15:0] cb,
                                     input logic [31:0] t);
    result_t r;
    r.kind       = k;
    r.packed_msg = p;
    r.sx_data    = sx;
    r.chunk      = cb;
    r.stamp      = t;
    r.last       = 1'b0;
    return r;
  endfunction

  // Saturating increment of the chunk fill count.
  function automatic logic [15:0] fill_inc(input logic [15:0] f);
    return (f == FILL_MAX) ? f : f + 16'd1;
  endfunction

  // Handling of a non-real-time byte while no SysEx is open.
  function automatic outside_t outside_byte(input logic [7:0] b, input pend_t pend,
                                            input logic [15:0] fill,
                                            input logic [31:0] t);
    outside_t   o;
    logic [1:0] len;
    o.pend  = pend;
    o.sysex = 1'b0;
    o.fill  = fill;
    o.hit   = 1'b0;
    o.res   = mk_res(KIND_SHORT, 24'd0, 8'd0, 16'd0, t);
    len     = msg_len(pend.status);
    if (b == BYTE_SX_END) begin
      // Stray end of SysEx.
      o.pend = '0;
      o.hit  = 1'b1;
      o.res  = mk_res(KIND_STRAY, {16'd0, b}, 8'd0, 16'd0, t);
    end else if (b == BYTE_SX_START) begin
      // SysEx opens and its first byte goes into the chunk.
      o.pend  = '0;
      o.sysex = 1'b1;
      o.fill  = fill_inc(fill);
      o.hit   = 1'b1;
      o.res   = mk_res(KIND_SXBYTE, 24'd0, b, 16'd0, t);
    end else if (b[7]) begin
      // New status byte; one-byte messages go out at once.
      o.pend        = '0;
      o.pend.status = b;
      o.pend.count  = 2'd1;
      if (msg_len(b) == 2'd1) begin
        o.pend = '0;
        o.hit  = 1'b1;
        o.res  = mk_res(KIND_SHORT, {16'd0, b}, 8'd0, 16'd0, t);
      end
    end else if (pend.count == 2'd1) begin
      o.pend.first = b[6:0];
      o.pend.count = 2'd2;
      if (len == 2'd2) begin
        o.pend = '0;
        o.hit  = 1'b1;
        o.res  = mk_res(KIND_SHORT, {8'd0, 1'b0, b[6:0], pend.status},
                        8'd0, 16'd0, t);
      end
    end else if (pend.count == 2'd2) begin
      o.pend.second = b[6:0];
      o.pend.count  = 2'd3;
      if (len == 2'd3) begin
        o.pend = '0;
        o.hit  = 1'b1;
        o.res  = mk_res(KIND_SHORT,
                        {1'b0, b[6:0], 1'b0, pend.first, pend.status},
                        8'd0, 16'd0, t);
      end
    end
    return o;
  endfunction

  // Input register.
  logic        in_vld_q, in_vld_d;
  cmd_e        in_cmd_q;
  logic [7:0]  in_byte_q;
  logic [31:0] in_time_q;
  logic        in_take;
  logic        go;

  // Parser state.
  logic        running_q, running_d;
  logic        sysex_q, sysex_d;
  pend_t       pend_q, pend_d;
  logic [15:0] fill_q, fill_d;
  logic [15:0] len_q;

  // Results of the item being parsed.
  result_t     r0, r1;
  logic [1:0]  n_res;
  outside_t    ob;
  logic [15:0] fill_add;
  logic        from_sysex;

  // Result queue.
  result_t           q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] rd_ptr_q, wr_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              pop;

  // Input handshake: the item moves on as soon as two queue entries are free.
  assign go         = in_vld_q && (cnt_q <= QCNT_W'(QUEUE_DEPTH - 2));
  assign in_stall_o = in_vld_q && !go;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (go) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_cmd_q  <= command_i;
      in_byte_q <= data_byte_i;
      in_time_q <= time_stamp_i;
    end
  end

  // Configuration register, writable in every cycle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= CHUNK_LEN_RESET;
    end else if (cfg_valid_i) begin
      len_q <= cfg_data_i;
    end
  end

  // Parse the registered item against the current state.
  assign from_sysex = in_cmd_q == CMD_DATA && running_q && sysex_q &&
                      in_byte_q[7] && in_byte_q != BYTE_SX_END &&
                      in_byte_q < BYTE_RT_FIRST;
  assign ob         = outside_byte(in_byte_q, pend_q, from_sysex ? 16'd0 : fill_q,
                                   in_time_q);
  assign fill_add   = fill_inc(fill_q);

  always_comb begin
    running_d = running_q;
    sysex_d   = sysex_q;
    pend_d    = pend_q;
    fill_d    = fill_q;
    n_res     = 2'd0;
    r0        = mk_res(KIND_SHORT, 24'd0, 8'd0, 16'd0, in_time_q);
    r1        = mk_res(KIND_SHORT, 24'd0, 8'd0, 16'd0, in_time_q);
    case (in_cmd_q)
      CMD_START: begin
        running_d = 1'b1;
      end
      CMD_STOP: begin
        running_d = 1'b0;
        if (sysex_q) begin
          n_res   = 2'd1;
          r0      = mk_res((fill_q != 16'd0) ? KIND_ERROR : KIND_DONE, 24'd0, 8'd0,
                           fill_q, in_time_q);
          fill_d  = 16'd0;
          sysex_d = 1'b0;
        end
      end
      CMD_RESET: begin
        running_d = 1'b0;
        sysex_d   = 1'b0;
        pend_d    = '0;
        fill_d    = 16'd0;
      end
      default: begin
        if (running_q) begin
          if (in_byte_q >= BYTE_RT_FIRST) begin
            // Real-time byte passes straight through.
            n_res = 2'd1;
            r0    = mk_res(KIND_SHORT, {16'd0, in_byte_q}, 8'd0, 16'd0, in_time_q);
          end else if (!sysex_q) begin
            pend_d  = ob.pend;
            sysex_d = ob.sysex;
            fill_d  = ob.fill;
            n_res   = {1'b0, ob.hit};
            r0      = ob.res;
          end else if (from_sysex) begin
            // Status byte cuts the SysEx short, then is parsed as usual.
            r0      = mk_res((fill_q != 16'd0) ? KIND_ERROR : KIND_DONE, 24'd0,
                             8'd0, fill_q, in_time_q);
            r1      = ob.res;
            n_res   = ob.hit ? 2'd2 : 2'd1;
            pend_d  = ob.pend;
            sysex_d = ob.sysex;
            fill_d  = ob.fill;
          end else begin
            // Byte stored into the chunk.
            n_res  = 2'd1;
            r0     = mk_res(KIND_SXBYTE, 24'd0, in_byte_q, 16'd0, in_time_q);
            fill_d = fill_add;
            if (in_byte_q == BYTE_SX_END) begin
              n_res   = 2'd2;
              r1      = mk_res(KIND_DONE, 24'd0, 8'd0, fill_add, in_time_q);
              fill_d  = 16'd0;
              sysex_d = 1'b0;
            end else if (fill_add >= len_q) begin
              n_res  = 2'd2;
              r1     = mk_res(KIND_DONE, 24'd0, 8'd0, fill_add, in_time_q);
              fill_d = 16'd0;
            end
          end
        end
      end
    endcase
    // Mark the final result of the item.
    if (n_res == 2'd2) begin
      r1.last = 1'b1;
    end else begin
      r0.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      sysex_q   <= 1'b0;
      pend_q    <= '0;
      fill_q    <= 16'd0;
    end else if (go) begin
      running_q <= running_d;
      sysex_q   <= sysex_d;
      pend_q    <= pend_d;
      fill_q    <= fill_d;
    end
  end

  // Result queue: up to two writes and one read per cycle.
  assign pop = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (go && n_res != 2'd0) begin
      q_mem[wr_ptr_q] <= r0;
    end
    if (go && n_res == 2'd2) begin
      q_mem[wr_ptr_q + QPTR_W'(1)] <= r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (go) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(n_res);
      end
      cnt_q <= cnt_q + (go ? QCNT_W'(n_res) : QCNT_W'(0)) - QCNT_W'(pop);
    end
  end

  // Result port shows the head of the queue.
  assign out_valid_o      = cnt_q != '0;
  assign kind_o           = q_mem[rd_ptr_q].kind;
  assign packed_message_o = q_mem[rd_ptr_q].packed_msg;
  assign sysex_data_o     = q_mem[rd_ptr_q].sx_data;
  assign chunk_bytes_o    = q_mem[rd_ptr_q].chunk;
  assign result_time_o    = q_mem[rd_ptr_q].stamp;
  assign last_o           = q_mem[rd_ptr_q].last;

endmodule

`default_nettype wire

### sv/mibp_checker.sv
// ----------------------------------------------------------------------------
// MIDI input byte parser port checker
// Watches the parser's ports and checks result fields and handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module mibp_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input mibp_pkg::kind_e  kind_o,
  input logic [23:0]      packed_message_o,
  input logic [7:0]       sysex_data_o,
  input logic [15:0]      chunk_bytes_o,
  input logic [31:0]      result_time_o,
  input logic             last_o
);

  import mibp_pkg::*;

  // A stalled result stays in place.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) &&
      $stable(packed_message_o) && $stable(sysex_data_o) &&
      $stable(chunk_bytes_o) && $stable(result_time_o) && $stable(last_o))
    else $error("stalled result changed");

  // Only chunk results carry a byte count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_SHORT || kind_o == KIND_SXBYTE ||
      kind_o == KIND_STRAY) |-> chunk_bytes_o == 16'd0)
    else $error("byte count on a non-chunk result");

  // An error completion always has bytes in its chunk.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_ERROR |-> chunk_bytes_o != 16'd0)
    else $error("chunk error with an empty chunk");

  // A stray end always reports the end-of-SysEx byte and ends its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_STRAY |->
      packed_message_o == {16'd0, BYTE_SX_END} && last_o && sysex_data_o == 8'd0)
    else $error("malformed stray end result");

endmodule

bind midi_input_byte_parser mibp_checker u_mibp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .kind_o           (kind_o),
  .packed_message_o (packed_message_o),
  .sysex_data_o     (sysex_data_o),
  .chunk_bytes_o    (chunk_bytes_o),
  .result_time_o    (result_time_o),
  .last_o           (last_o)
);

`default_nettype wire
